[rtl/core/cdod_pkg.sv]
// shared constants, types and the cordic angle table for the onset detector
package cdod_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int POS_W      = $clog2(MAX_BINS);
  localparam int NB_W       = 11;
  localparam int CW         = 36;   // cordic datapath width
  localparam int ZW         = 18;   // cordic angle width
  localparam int SQ_W       = 36;   // square-root operand width
  localparam int RT_W       = 18;   // square-root result width
  localparam int ACC_W      = CW + 17;   // gain multiply accumulator width
  localparam int MAG_W      = 17;
  localparam int PH_W       = 16;
  localparam int SUM_W      = 28;
  localparam int ODF_W      = 18;
  localparam int WORD_W     = MAG_W + 2 * PH_W;
  localparam logic [15:0] GAIN_Q16 = 16'd39797;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes
  localparam logic [1:0] REG_NUM_BINS  = 2'd0;
  localparam logic [1:0] REG_RECTIFIED = 2'd1;

  // request to the shared cordic unit
  typedef struct packed {
    logic                 start;
    logic                 rotate;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [ZW-1:0] z0;
  } cordic_req_t;

  // binary angle of atan(2^-i), 65536 per turn
  function automatic logic signed [ZW-1:0] atan_at(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = 18'sd8192;
      4'd1:    a = 18'sd4836;
      4'd2:    a = 18'sd2555;
      4'd3:    a = 18'sd1297;
      4'd4:    a = 18'sd651;
      4'd5:    a = 18'sd326;
      4'd6:    a = 18'sd163;
      4'd7:    a = 18'sd81;
      4'd8:    a = 18'sd41;
      4'd9:    a = 18'sd20;
      4'd10:   a = 18'sd10;
      4'd11:   a = 18'sd5;
      4'd12:   a = 18'sd3;
      4'd13:   a = 18'sd1;
      4'd14:   a = 18'sd1;
      default: a = 18'sd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/cdod_ram.sv]
// generic single-write, single-read ram with registered read data
module cdod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cdod_cordic.sv]
// iterative cordic, one micro-rotation per cycle, vectoring or rotation mode
module cdod_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cdod_pkg::cordic_req_t                 req,
  output logic                                  done,
  output logic signed [cdod_pkg::CW-1:0]        x,
  output logic signed [cdod_pkg::CW-1:0]        y,
  output logic signed [cdod_pkg::ZW-1:0]        z
);

  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic                           rot_r;
  logic [3:0]                     step_r;
  logic signed [cdod_pkg::CW-1:0] x_r, y_r;
  logic signed [cdod_pkg::ZW-1:0] z_r;
  logic signed [cdod_pkg::CW-1:0] xs, ys;
  logic                           up;

  // shifted operands and direction of this step
  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    up = rot_r ? (z_r >= 0) : (y_r < 0);
  end

  // control
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
    end else if (run_r && step_r == 4'd15) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= req.x0;
      y_r    <= req.y0;
      z_r    <= req.z0;
      rot_r  <= req.rotate;
      step_r <= 4'd0;
    end else if (run_r) begin
      if (up) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - cdod_pkg::atan_at(step_r);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + cdod_pkg::atan_at(step_r);
      end
      step_r <= step_r + 4'd1;
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

[rtl/core/cdod_isqrt.sv]
// iterative floor square root, one result bit per cycle
module cdod_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cdod_pkg::SQ_W-1:0]       value,
  output logic                            done,
  output logic [cdod_pkg::RT_W-1:0]       root
);

  logic                          run_r, done_r;
  logic [4:0]                    cnt_r;
  logic [cdod_pkg::SQ_W-1:0]     val_r;
  logic [cdod_pkg::RT_W:0]       rem_r;
  logic [cdod_pkg::RT_W-1:0]     root_r;
  logic [cdod_pkg::RT_W+2:0]     rem_sh, trial;

  // trial subtraction for this bit
  always_comb begin
    rem_sh = {rem_r, val_r[cdod_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && cnt_r == 5'(cdod_pkg::RT_W - 1);
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'(cdod_pkg::RT_W - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (run_r) begin
      val_r <= {val_r[cdod_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= (cdod_pkg::RT_W + 1)'(rem_sh - trial);
        root_r <= {root_r[cdod_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= (cdod_pkg::RT_W + 1)'(rem_sh);
        root_r <= {root_r[cdod_pkg::RT_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/core/complex_domain_onset_detector_top.sv]
// complex-domain onset detector: sequencer, shared multiplier and divider
//
//  port group  dir  beat contents
//  in_*        in   one spectrum bin: bin_re, bin_im
//  out_*       out  onset value odf_value, one per frame from the third on
//  cfg_*       in   register write: 0 num_bins, 1 rectified
//
// a bin in the first two frames passes the iterative square root and one
// pass of the shared cordic; after that it also takes a second cordic
// pass, the bit-serial gain multiply and a second square root; the last
// bin of an emitting frame adds a restoring division.
// rst_n is synchronous; the bin history ram is not cleared.
// input is taken only between bins; a stalled result holds while the next
// bins are taken, and the frame end waits for the result slot to free.
module complex_domain_onset_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] bin_re, [31:16] bin_im
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [17:0] odf_value, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_SQ1  = 13'b0000000000010,
    S_SQ2  = 13'b0000000000100,
    S_MAG  = 13'b0000000001000,
    S_VEC  = 13'b0000000010000,
    S_ROT  = 13'b0000000100000,
    S_GAIN = 13'b0000001000000,
    S_ESQ1 = 13'b0000010000000,
    S_ESQ2 = 13'b0000100000000,
    S_ERR  = 13'b0001000000000,
    S_FIN  = 13'b0010000000000,
    S_DIV  = 13'b0100000000000,
    S_EMIT = 13'b1000000000000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [cdod_pkg::NB_W-1:0]           num_bins_r;
  logic                                rect_r;
  logic [cdod_pkg::POS_W-1:0]          pos_r;
  logic [1:0]                          frames_r;
  logic [cdod_pkg::SUM_W-1:0]          sum_r;
  logic signed [15:0]                  re_r, im_r;
  logic [cdod_pkg::MAG_W-1:0]          mag_r;
  logic [cdod_pkg::WORD_W-1:0]         old_r, ram_rdata, ram_wdata;
  logic                                ram_we;
  logic [cdod_pkg::SQ_W-1:0]           prod_r;
  logic signed [cdod_pkg::CW-1:0]      cx_r, cy_r;
  logic signed [cdod_pkg::ACC_W-1:0]   accx_r, accy_r;
  logic [3:0]                          gcnt_r;
  logic [4:0]                          dcnt_r;
  logic [cdod_pkg::SUM_W-1:0]          q_r;
  logic [cdod_pkg::NB_W-1:0]           drem_r;
  logic                                out_valid_r;
  logic [cdod_pkg::ODF_W-1:0]          out_data_r;

  logic [cdod_pkg::NB_W-1:0]           n_eff;
  logic                                last_bin;
  logic signed [17:0]                  mul_a, dre, dim;
  logic signed [35:0]                  mul_p;
  logic                                sq_start, sq_done;
  logic [cdod_pkg::SQ_W-1:0]           sq_value;
  logic [cdod_pkg::RT_W-1:0]           sq_root;
  cdod_pkg::cordic_req_t               creq;
  logic                                cd_done;
  logic signed [cdod_pkg::CW-1:0]      cd_x, cd_y;
  logic signed [cdod_pkg::ZW-1:0]      cd_z;
  logic signed [cdod_pkg::CW-1:0]      vx0, vy0;
  logic [cdod_pkg::PH_W-1:0]           old_mag_ph, old_older_ph, target;
  logic [cdod_pkg::MAG_W-1:0]          old_mag;
  logic                                rot_neg;
  logic [cdod_pkg::SUM_W:0]            sum_add;
  logic [cdod_pkg::RT_W-1:0]           err;
  logic [cdod_pkg::NB_W:0]             drem_sh;
  logic                                in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // effective bins per frame and end-of-frame test
  always_comb begin
    if (num_bins_r == '0) begin
      n_eff = cdod_pkg::NB_W'(1);
    end else if (num_bins_r > cdod_pkg::NB_W'(cdod_pkg::MAX_BINS)) begin
      n_eff = cdod_pkg::NB_W'(cdod_pkg::MAX_BINS);
    end else begin
      n_eff = num_bins_r;
    end
    last_bin = (cdod_pkg::NB_W'(pos_r) + cdod_pkg::NB_W'(1)) >= n_eff;
  end

  // stored history of this bin
  assign old_mag      = old_r[cdod_pkg::MAG_W-1:0];
  assign old_mag_ph   = old_r[cdod_pkg::MAG_W +: cdod_pkg::PH_W];
  assign old_older_ph = old_r[cdod_pkg::MAG_W + cdod_pkg::PH_W +: cdod_pkg::PH_W];

  cdod_ram #(
    .WIDTH (cdod_pkg::WORD_W),
    .DEPTH (cdod_pkg::MAX_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == S_VEC) && cd_done;
  assign ram_wdata = {old_mag_ph, cd_z[cdod_pkg::PH_W-1:0], mag_r};

  // shared squaring multiplier
  assign dre = 18'(accx_r[49:32]) - 18'(re_r);
  assign dim = 18'(accy_r[49:32]) - 18'(im_r);
  always_comb begin
    case (state_r)
      S_SQ1:   mul_a = 18'(re_r);
      S_SQ2:   mul_a = 18'(im_r);
      S_ESQ1:  mul_a = dre;
      default: mul_a = dim;
    endcase
    mul_p = mul_a * mul_a;
  end

  assign sq_start = (state_r == S_SQ2) || (state_r == S_ESQ2);
  assign sq_value = prod_r + cdod_pkg::SQ_W'(mul_p);

  cdod_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  // cordic requests: vectoring for the phase, rotation for the prediction
  assign target  = cdod_pkg::PH_W'({old_mag_ph, 1'b0} - old_older_ph);
  assign rot_neg = target[15] ^ target[14];
  always_comb begin
    vx0 = cdod_pkg::CW'(re_r) <<< 4;
    vy0 = cdod_pkg::CW'(im_r) <<< 4;
    creq = '0;
    if (state_r == S_MAG && sq_done) begin
      creq.start  = 1'b1;
      creq.rotate = 1'b0;
      creq.x0     = re_r[15] ? -vx0 : vx0;
      creq.y0     = re_r[15] ? -vy0 : vy0;
      creq.z0     = re_r[15] ? 18'sd32768 : 18'sd0;
    end else if (state_r == S_VEC && cd_done && frames_r == 2'd2) begin
      creq.start  = 1'b1;
      creq.rotate = 1'b1;
      creq.x0     = cdod_pkg::CW'({old_mag, 16'b0});
      creq.y0     = '0;
      creq.z0     = cdod_pkg::ZW'($signed(rot_neg ? (target ^ 16'h8000) : target));
    end
  end

  cdod_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .done  (cd_done),
    .x     (cd_x),
    .y     (cd_y),
    .z     (cd_z)
  );

  // error of this bin and saturating frame sum
  assign err     = (rect_r && old_mag > mag_r) ? '0 : sq_root;
  assign sum_add = {1'b0, sum_r} + (cdod_pkg::SUM_W + 1)'(err);
  assign drem_sh = {drem_r, q_r[cdod_pkg::SUM_W-1]};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SQ1;
      S_SQ1:  state_nxt = S_SQ2;
      S_SQ2:  state_nxt = S_MAG;
      S_MAG:  if (sq_done) state_nxt = S_VEC;
      S_VEC: begin
        if (cd_done) state_nxt = (frames_r == 2'd2) ? S_ROT : S_FIN;
      end
      S_ROT:  if (cd_done) state_nxt = S_GAIN;
      S_GAIN: if (gcnt_r == 4'd0) state_nxt = S_ESQ1;
      S_ESQ1: state_nxt = S_ESQ2;
      S_ESQ2: state_nxt = S_ERR;
      S_ERR:  if (sq_done) state_nxt = S_FIN;
      S_FIN: begin
        if (last_bin && frames_r == 2'd2) state_nxt = S_DIV;
        else                              state_nxt = S_IDLE;
      end
      S_DIV:  if (dcnt_r == 5'd0) state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_bins_r  <= cdod_pkg::NB_W'(513);
      rect_r      <= 1'b0;
      pos_r       <= '0;
      frames_r    <= 2'd0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cdod_pkg::REG_NUM_BINS:  num_bins_r <= cfg_data;
          cdod_pkg::REG_RECTIFIED: rect_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == S_ERR && sq_done) begin
        sum_r <= sum_add[cdod_pkg::SUM_W] ? cdod_pkg::SUM_MAX : sum_add[cdod_pkg::SUM_W-1:0];
      end
      if (state_r == S_FIN) begin
        if (!last_bin) begin
          pos_r <= pos_r + cdod_pkg::POS_W'(1);
        end else if (frames_r != 2'd2) begin
          frames_r <= frames_r + 2'd1;
          sum_r    <= '0;
          pos_r    <= '0;
        end
      end
      if (state_r == S_EMIT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        pos_r       <= '0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      re_r <= $signed(in_tdata[15:0]);
      im_r <= $signed(in_tdata[31:16]);
    end
    if (state_r == S_SQ1) begin
      old_r <= ram_rdata;
    end
    if (state_r == S_SQ1 || state_r == S_ESQ1) begin
      prod_r <= cdod_pkg::SQ_W'(mul_p);
    end
    if (state_r == S_MAG && sq_done) begin
      mag_r <= sq_root[cdod_pkg::MAG_W-1:0];
    end
    if (state_r == S_ROT && cd_done) begin
      cx_r   <= (old_r[cdod_pkg::MAG_W-1:0] != '0 && rot_neg) ? -cd_x : cd_x;
      cy_r   <= rot_neg ? -cd_y : cd_y;
      accx_r <= '0;
      accy_r <= '0;
      gcnt_r <= 4'd15;
    end
    if (state_r == S_GAIN) begin
      accx_r <= (accx_r <<< 1) +
                (cdod_pkg::GAIN_Q16[gcnt_r] ? cdod_pkg::ACC_W'(cx_r) : '0);
      accy_r <= (accy_r <<< 1) +
                (cdod_pkg::GAIN_Q16[gcnt_r] ? cdod_pkg::ACC_W'(cy_r) : '0);
      gcnt_r <= gcnt_r - 4'd1;
    end
    if (state_r == S_FIN) begin
      q_r    <= sum_r;
      drem_r <= '0;
      dcnt_r <= 5'(cdod_pkg::SUM_W - 1);
    end
    if (state_r == S_DIV) begin
      if (drem_sh >= {1'b0, n_eff}) begin
        drem_r <= cdod_pkg::NB_W'(drem_sh - {1'b0, n_eff});
        q_r    <= {q_r[cdod_pkg::SUM_W-2:0], 1'b1};
      end else begin
        drem_r <= cdod_pkg::NB_W'(drem_sh);
        q_r    <= {q_r[cdod_pkg::SUM_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 5'd1;
    end
    if (state_r == S_EMIT && (!out_valid_r || out_tready)) begin
      out_data_r <= q_r[cdod_pkg::ODF_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  // a new result appears only out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit step");

  // nothing is summed during the first two frames
  a_sum_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    (frames_r != 2'd2) |-> (sum_r == '0))
    else $error("error sum nonzero before third frame");

  // frame counter saturates at two
  a_frames_sat: assert property (@(posedge clk) disable iff (!rst_n)
    frames_r != 2'd3)
    else $error("frame counter overran");

  // an accepted bin starts the squaring step next cycle
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SQ1))
    else $error("accepted bin did not start processing");

endmodule
